>>> design/lmdv_pkg.sv
// ============================================================================
// lmdv_pkg
// Shared types and constants of the vibrato delay block.
// ============================================================================
package lmdv_pkg;

    // Sample and LFO value widths
    localparam int SAMPLE_W = 24;
    localparam int SU_W     = 25;     // sine or triangle plus one, Q23, 0..2^24
    localparam int ROM_W    = 23;     // quarter-wave entry, Q23, positive

    // Offset-binary bias for 24-bit samples
    localparam logic [SAMPLE_W-1:0] BIAS23  = 24'h80_0000;
    localparam logic [SU_W-1:0]     SU_BIAS = 25'h080_0000;

    // Sine table build constants (Q30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Taylor series divisors (2j)*(2j+1), j = 1..8
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SU_W-1:0]     sine_pos_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_DEPTH_KNOB = 2'd1,
        REG_WAVE_MIX   = 2'd2
    } cfg_reg_t;

endpackage

>>> design/lmdv_ram.sv
// ============================================================================
// lmdv_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ============================================================================
module lmdv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/lmdv_sine_rom.sv
// ============================================================================
// lmdv_sine_rom
// Full-cycle sine lookup from a quarter-wave table, returns sine + 1 in Q23.
// The table read is registered, gated by en.
// ============================================================================
module lmdv_sine_rom
    import lmdv_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic [$clog2(4*SINE_TABLE_SIZE)-1:0]   sidx,   // 0 .. 4N-1
    output sine_pos_t                              su
);

    localparam int N     = SINE_TABLE_SIZE;
    localparam int AW    = $clog2(N);
    localparam int IDX_W = $clog2(4*N);
    localparam int TWO_N = 2*N;

    typedef logic [ROM_W-1:0] rom_t [N];

    // Quarter-wave table, built at elaboration with an integer Taylor series
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k < N; k++) begin
            x  = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) / 64'(TWO_N);
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int j = 8; j >= 1; j--) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[j];
            end
            s = (x * t) >> 30;
            s = (s + 64'd64) >> 7;
            if (s > 64'd8388607) begin
                s = 64'd8388607;
            end
            rom[k] = s[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [1:0]       quad;
    logic [IDX_W-1:0] off_i;
    logic [AW-1:0]    addr;
    logic [ROM_W-1:0] rom_reg;
    logic [1:0]       quad_reg;

    // Quadrant split and mirrored address
    always_comb begin
        if (sidx >= IDX_W'(3*N)) begin
            quad  = 2'd3;
            off_i = sidx - IDX_W'(3*N);
        end else if (sidx >= IDX_W'(2*N)) begin
            quad  = 2'd2;
            off_i = sidx - IDX_W'(2*N);
        end else if (sidx >= IDX_W'(N)) begin
            quad  = 2'd1;
            off_i = sidx - IDX_W'(N);
        end else begin
            quad  = 2'd0;
            off_i = sidx;
        end
        addr = quad[0] ? (AW'(N-1) - off_i[AW-1:0]) : off_i[AW-1:0];
    end

    // Registered table read
    always_ff @(posedge aclk) begin
        if (en) begin
            rom_reg  <= SINE_ROM[addr];
            quad_reg <= quad;
        end
    end

    // Second half of the cycle is negative
    assign su = quad_reg[1] ? (SU_BIAS - SU_W'(rom_reg)) : (SU_BIAS + SU_W'(rom_reg));

endmodule

>>> design/lfo_modulated_delay_vibrato.sv
// ============================================================================
// lfo_modulated_delay_vibrato
// Per-channel vibrato: circular delay store swept by a sine/triangle LFO,
// read out with linear interpolation.
//   Sequence: PHASE, QUAD, MIX, SUM, DEPTH, POS, ADDR, RDA, RDB, MULB, OUT;
//   OUT holds while the result stalls, and a channel number not below
//   CHANNELS goes straight to OUT. A new item waits for IDLE: the sequencer
//   walks the multiply chain and two delay-store reads via one RAM read port.
//   Reset: synchronous; configuration to defaults, LFO phases and write
//   positions to zero, per-channel fill counts to zero so the store reads as
//   silence until written. No clearing pass.
// ============================================================================
module lfo_modulated_delay_vibrato
    import lmdv_pkg::*;
#(
    parameter int DELAY_LENGTH    = 64,
    parameter int CHANNELS        = 2,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] sample_in
    input  logic [0:0]  s_tuser,    // [0] channel
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [23:0] sample_out
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int PTR_W     = $clog2(DELAY_LENGTH);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = CHANNELS * DELAY_LENGTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int FILL_W    = $clog2(DELAY_LENGTH + 1);
    localparam int IDX_W     = $clog2(4 * SINE_TABLE_SIZE);
    localparam int PROD_W    = 32 + IDX_W;
    localparam int RP_W      = PTR_W + 17;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DELAY_LENGTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DELAY_LENGTH - 1);
    localparam logic [PTR_W:0]    LEN_INT   = (PTR_W+1)'(DELAY_LENGTH);
    localparam logic [RP_W-1:0]   LEN_Q16   = RP_W'(DELAY_LENGTH * 65536);
    localparam logic [20:0]       DELAY_MIN = 21'(6 * 65536);
    localparam logic [20:0]       DELAY_LIM = 21'(16 * 65536);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PHASE = 12'b0000_0000_0010,
        S_QUAD  = 12'b0000_0000_0100,
        S_MIX   = 12'b0000_0000_1000,
        S_SUM   = 12'b0000_0001_0000,
        S_DEPTH = 12'b0000_0010_0000,
        S_POS   = 12'b0000_0100_0000,
        S_ADDR  = 12'b0000_1000_0000,
        S_RDA   = 12'b0001_0000_0000,
        S_RDB   = 12'b0010_0000_0000,
        S_MULB  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] phase_step_reg;
    logic [15:0] depth_knob_reg;
    logic [15:0] wave_mix_reg;

    // per-channel state
    logic [PTR_W-1:0]  wp_reg    [CHANNELS];
    logic [31:0]       phase_reg [CHANNELS];
    logic [FILL_W-1:0] fill_reg  [CHANNELS];

    // current item
    logic [CH_W-1:0]   ch_reg;
    sample_t           smp_reg;
    logic              bad_reg;
    logic [PTR_W-1:0]  item_wp_reg;
    logic [31:0]       item_ph_reg;
    logic [FILL_W-1:0] item_fill_reg;

    // datapath registers
    logic [IDX_W-1:0]  sidx_reg;
    logic [SU_W-1:0]   tri_reg;
    logic [40:0]       prod_s_reg;
    logic [40:0]       prod_t_reg;
    logic [40:0]       mix_sum_reg;
    logic [40:0]       dprod_hi_reg;
    logic [39:0]       dprod_lo_reg;
    logic [20:0]       delay_reg;
    logic [PTR_W-1:0]  idx_a_reg;
    logic [PTR_W-1:0]  idx_b_reg;
    logic [15:0]       frac_reg;
    logic [40:0]       interp_a_reg;
    logic [39:0]       interp_b_reg;
    logic              m_tvalid_reg;
    sample_t           m_tdata_reg;

    // combinational
    logic              s_acc;
    logic              ch_in_bad;
    logic [CH_W-1:0]   ch_in;
    logic [MEM_AW-1:0] base_addr;
    logic              ram_wr_en;
    logic [MEM_AW-1:0] ram_wr_addr;
    logic [MEM_AW-1:0] ram_rd_addr;
    sample_t           ram_rd_data;
    sine_pos_t         su;
    logic [PROD_W-1:0] phase_prod;
    logic [31:0]       tri_d;
    logic [FILL_W-1:0] fill_new;
    logic [16:0]       mix_inv;
    logic [19:0]       dk10;
    logic [60:0]       dprod_full;
    logic [RP_W-1:0]   rp;
    logic [PTR_W:0]    rp_int;
    logic [PTR_W:0]    rp_mod;
    logic [PTR_W-1:0]  idx_a;
    logic [PTR_W-1:0]  idx_b;
    sample_t           a_off;
    sample_t           b_off;
    logic [40:0]       isum;
    sample_t           interp_r;
    logic              out_load;

    assign s_acc     = s_tvalid && s_tready;
    assign ch_in_bad = 32'(s_tuser) >= 32'(CHANNELS);
    assign ch_in     = CH_W'(s_tuser);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // Delay store: one row of DELAY_LENGTH per channel
    assign base_addr   = MEM_AW'(ch_reg) * MEM_AW'(DELAY_LENGTH);
    assign ram_wr_en   = (state_reg == S_PHASE);
    assign ram_wr_addr = base_addr + MEM_AW'(item_wp_reg);
    assign ram_rd_addr = base_addr + MEM_AW'((state_reg == S_RDA) ? idx_a_reg : idx_b_reg);

    lmdv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (smp_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lmdv_sine_rom #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_sine (
        .aclk (aclk),
        .en   (state_reg == S_QUAD),
        .sidx (sidx_reg),
        .su   (su)
    );

    // Phase to table index, triangle, fill count, mix and depth terms
    always_comb begin
        phase_prod = PROD_W'(item_ph_reg) * PROD_W'(4 * SINE_TABLE_SIZE);
        tri_d      = item_ph_reg[31] ? (item_ph_reg - 32'h8000_0000)
                                     : (32'h8000_0000 - item_ph_reg);
        fill_new   = (item_fill_reg == FILL_FULL) ? FILL_FULL : (item_fill_reg + 1'b1);
        mix_inv    = 17'h1_0000 - 17'(wave_mix_reg);
        dk10       = 20'(depth_knob_reg) * 20'd10;
        dprod_full = {dprod_hi_reg, 20'h0_0000} + 61'(dprod_lo_reg);
    end

    // Read position: integer part modulo the store length, neighbor wraps
    always_comb begin
        rp     = RP_W'({item_wp_reg, 16'h0000}) + LEN_Q16 - RP_W'(delay_reg);
        rp_int = rp[RP_W-1:16];
        rp_mod = (rp_int >= LEN_INT) ? (rp_int - LEN_INT) : rp_int;
        idx_a  = rp_mod[PTR_W-1:0];
        idx_b  = (idx_a == PTR_LAST) ? '0 : (idx_a + 1'b1);
    end

    // Unwritten entries read as zero (offset-binary bias)
    always_comb begin
        a_off = (FILL_W'(idx_a_reg) < item_fill_reg) ? (ram_rd_data ^ BIAS23) : BIAS23;
        b_off = (FILL_W'(idx_b_reg) < item_fill_reg) ? (ram_rd_data ^ BIAS23) : BIAS23;
    end

    // Interpolation sum, rounding and saturation
    always_comb begin
        isum     = interp_a_reg + 41'(interp_b_reg) + 41'd32768;
        interp_r = isum[40] ? sample_t'(24'hFF_FFFF) : isum[39:16];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  begin
                if (s_acc) begin
                    state_next = ch_in_bad ? S_OUT : S_PHASE;
                end
            end
            S_PHASE: state_next = S_QUAD;
            S_QUAD:  state_next = S_MIX;
            S_MIX:   state_next = S_SUM;
            S_SUM:   state_next = S_DEPTH;
            S_DEPTH: state_next = S_POS;
            S_POS:   state_next = S_ADDR;
            S_ADDR:  state_next = S_RDA;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_MULB;
            S_MULB:  state_next = S_OUT;
            S_OUT:   begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and per-channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_step_reg <= 32'd134218;
            depth_knob_reg <= '0;
            wave_mix_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                wp_reg[c]    <= '0;
                phase_reg[c] <= '0;
                fill_reg[c]  <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                    REG_DEPTH_KNOB: depth_knob_reg <= cfg_wdata[15:0];
                    REG_WAVE_MIX:   wave_mix_reg   <= cfg_wdata[15:0];
                    default:        ;
                endcase
            end

            // advance the channel once its sample is stored
            if (state_reg == S_PHASE) begin
                wp_reg[ch_reg]    <= (item_wp_reg == PTR_LAST) ? '0 : (item_wp_reg + 1'b1);
                phase_reg[ch_reg] <= item_ph_reg + phase_step_reg;
                fill_reg[ch_reg]  <= fill_new;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    ch_reg        <= ch_in;
                    smp_reg       <= s_tdata;
                    bad_reg       <= ch_in_bad;
                    item_wp_reg   <= wp_reg[ch_in];
                    item_ph_reg   <= phase_reg[ch_in];
                    item_fill_reg <= fill_reg[ch_in];
                end
            end
            S_PHASE: begin
                sidx_reg      <= phase_prod[PROD_W-1:32];
                tri_reg       <= tri_d[31:7];
                item_fill_reg <= fill_new;
            end
            S_MIX: begin
                prod_s_reg <= 41'(su) * 41'(mix_inv);
                prod_t_reg <= 41'(tri_reg) * 41'(wave_mix_reg);
            end
            S_SUM: begin
                mix_sum_reg <= prod_s_reg + prod_t_reg;
            end
            S_DEPTH: begin
                dprod_hi_reg <= 41'(dk10) * 41'(mix_sum_reg[40:20]);
                dprod_lo_reg <= 40'(dk10) * 40'(mix_sum_reg[19:0]);
            end
            S_POS: begin
                delay_reg <= DELAY_MIN + dprod_full[60:40];
            end
            S_ADDR: begin
                idx_a_reg <= idx_a;
                idx_b_reg <= idx_b;
                frac_reg  <= rp[15:0];
            end
            S_RDB: begin
                interp_a_reg <= 41'(a_off) * 41'(17'h1_0000 - 17'(frac_reg));
            end
            S_MULB: begin
                interp_b_reg <= 40'(b_off) * 40'(frac_reg);
            end
            S_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= bad_reg ? '0 : (interp_r ^ BIAS23);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // taps never land on the slot just written
    a_tap_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDA) |-> (idx_a_reg != item_wp_reg) && (idx_b_reg != item_wp_reg))
        else $error("read tap hits current write slot");

    // delay stays inside its swing
    a_delay_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADDR) |-> (delay_reg >= DELAY_MIN) && (delay_reg < DELAY_LIM))
        else $error("delay out of range");

    // a stalled result keeps the sequencer in its output step
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) && m_tvalid_reg && !m_tready |=> (state_reg == S_OUT))
        else $error("sequencer left output step while result stalled");

    // every in-range transfer stores its sample next cycle
    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !ch_in_bad |=> ram_wr_en)
        else $error("accepted sample not written to store");

    // fill count covers at least the current sample and never overruns
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDB) |-> (item_fill_reg != '0) && (item_fill_reg <= FILL_FULL))
        else $error("fill count out of range");

endmodule

>>> test/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the two-channel vibrato delay. A directed table
// covers reset silence, sample extremes, full depth and both LFO shapes.
// Random bursts then run under several register settings, and every result
// transfer is checked against a bit-exact fixed-point predictor.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
    import lmdv_pkg::*;

    localparam int          TAP_LEN      = 64;
    localparam int          ROM_LEN      = 1024;
    localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;
    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam logic [31:0] STEP_DEFAULT = 32'd134218;
    localparam logic [1:0]  REG_UNMAPPED = 2'd3;   // no register behind this index
    localparam int          SETTLE_CYCLES = 14;
    localparam int          RAND_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 150;
    localparam int          DIR_ROWS      = 27;

    // One directed row: either a register write or a sample transfer
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        logic        chan;
        sample_t     smp;
        logic        typed;     // expected output given in the row
        sample_t     want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;     // [23:0] sample_in
    logic [0:0]  s_tuser   = '0;     // [0] channel
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [23:0] sample_out
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // Predictor state
    logic [22:0] sine_quarter [ROM_LEN];
    sample_t     tap_store [2][TAP_LEN];
    logic [5:0]  tap_wr_pos [2];
    logic [31:0] lfo_acc [2];
    logic [31:0] cfg_step;
    logic [15:0] cfg_depth;
    logic [15:0] cfg_mix;

    sample_t     expected_samples [$];
    sample_t     due_sample;
    int          mismatch_count = 0;
    dir_row_t    directed [DIR_ROWS];

    logic [5:0]  stall_tick = '0;
    logic [1:0]  stall_mode = '0;

    lfo_modulated_delay_vibrato dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Quarter-wave sine entry, Q23, from a Q30 Taylor series
    function automatic logic [22:0] sine_rom_value(int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int          j;
        x  = (Q30_HALF_PI * (64'd2 * 64'(k) + 64'd1)) / (64'd2 * 64'(ROM_LEN));
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (j = 8; j >= 1; j--)
            t = Q30_ONE - ((x2 * t) >> 30) / (64'(2 * j) * 64'(2 * j + 1));
        s = (x * t) >> 30;
        s = (s + 64'd64) >> 7;
        if (s > 64'd8388607)
            s = 64'd8388607;
        return s[22:0];
    endfunction

    // Register write as seen by the predictor; unmapped indexes do nothing
    function automatic void apply_register(logic [1:0] idx, logic [31:0] val);
        case (idx)
            REG_PHASE_STEP: cfg_step  = val;
            REG_DEPTH_KNOB: cfg_depth = val[15:0];
            REG_WAVE_MIX:   cfg_mix   = val[15:0];
            default: ;
        endcase
    endfunction

    // Store the sample, sweep the read tap by the LFO, interpolate two taps
    function automatic sample_t vibrato_sample(logic chan, sample_t smp);
        logic [5:0]  wp;
        logic [5:0]  idx;
        logic [5:0]  idx2;
        logic [31:0] ph;
        logic [31:0] tri_span;
        logic [9:0]  ofs;
        logic [22:0] rv;
        logic [63:0] su;
        logic [63:0] tu;
        logic [63:0] mix;
        logic [63:0] dly;
        logic [63:0] rp;
        logic [63:0] frac;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        wp = tap_wr_pos[chan];
        ph = lfo_acc[chan];
        tap_store[chan][wp] = smp;

        // sine + 1 from the quarter table, folded by quadrant
        ofs = ph[29:20];
        rv  = ph[30] ? sine_quarter[10'd1023 - ofs] : sine_quarter[ofs];
        su  = ph[31] ? (64'd8388608 - 64'(rv)) : (64'd8388608 + 64'(rv));

        // triangle + 1
        tri_span = ph[31] ? (ph - 32'h8000_0000) : (32'h8000_0000 - ph);
        tu       = 64'(tri_span >> 7);

        mix = su * (64'd65536 - 64'(cfg_mix)) + tu * 64'(cfg_mix);
        dly = (64'd6 << 16) + ((64'(cfg_depth) * 64'd10 * mix) >> 40);

        rp   = (64'(wp) << 16) + (64'(TAP_LEN) << 16) - dly;
        idx  = rp[21:16];
        frac = 64'(rp[15:0]);
        idx2 = idx + 6'd1;

        // interpolate on offset-binary values
        a = 64'(tap_store[chan][idx] ^ BIAS23);
        b = 64'(tap_store[chan][idx2] ^ BIAS23);
        r = (a * (64'd65536 - frac) + b * frac + 64'd32768) >> 16;
        if (r > 64'hFF_FFFF)
            r = 64'hFF_FFFF;

        tap_wr_pos[chan] = wp + 6'd1;
        lfo_acc[chan]    = ph + cfg_step;
        return r[23:0] ^ BIAS23;
    endfunction

    // One input transfer; valid is left high for a following transfer
    task automatic send_sample(logic chan, sample_t smp, logic typed, sample_t want);
        sample_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= chan;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = vibrato_sample(chan, smp);
        expected_samples.push_back(typed ? want : predicted);
    endtask

    // Register write once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_register(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic sample_t random_sample();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       return 24'h7F_FFFF;
                1:       return 24'h80_0000;
                2:       return 24'h00_0000;
                default: return 24'hFF_FFFF;
            endcase
        end
        return sample_t'($urandom);
    endfunction

    // Receiver: ready pattern changes mode each time the 6-bit stall_tick wraps
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == '0)
            stall_mode <= 2'($urandom_range(3));
        case (stall_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(1));
            2'd2:    m_tready <= ($urandom_range(3) == 0);
            default: m_tready <= (stall_tick[2:0] != 3'd0);
        endcase
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %06h", $time, m_tdata);
                mismatch_count++;
            end else begin
                due_sample = expected_samples.pop_front();
                if (m_tdata !== due_sample) begin
                    $display("%0t: sample_out mismatch, expected %06h, actual %06h",
                             $time, due_sample, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int          row;
        int          phase;
        int          sent;
        int          burst;
        int          gap;
        logic [31:0] step_val;
        logic [15:0] depth_val;
        logic [15:0] mix_val;

        // columns: is_cfg, reg, value, chan, sample, typed, expected
        directed = '{
            // reset: depth 0 gives a flat six-sample delay of silence
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h7F_FFFF, 1'b1, 24'h00_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h80_0000, 1'b1, 24'h00_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h00_0000, 1'b1, 24'h00_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'hFF_FFFF, 1'b1, 24'h00_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h00_0001, 1'b1, 24'h00_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h55_5555, 1'b1, 24'h00_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b1, 24'h12_3456, 1'b1, 24'h00_0000},
            // channel 0 echoes what it got six transfers ago
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'hAA_AAAA, 1'b1, 24'h7F_FFFF},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h7F_FFFE, 1'b1, 24'h80_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h80_0001, 1'b1, 24'h00_0000},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h2A_AAAA, 1'b1, 24'hFF_FFFF},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h00_0000, 1'b1, 24'h00_0001},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'hFF_FFFE, 1'b1, 24'h55_5555},
            // full depth, pure sine, half-cycle steps
            '{1'b1, REG_DEPTH_KNOB, 32'h0000_FFFF, 1'b0, 24'h0, 1'b0, 24'h0},
            '{1'b1, REG_PHASE_STEP, 32'h8000_0000, 1'b0, 24'h0, 1'b0, 24'h0},
            '{1'b1, REG_WAVE_MIX,   32'h0000_0000, 1'b0, 24'h0, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h7F_FFFF, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h80_0000, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b1, 24'h7F_FFFF, 1'b0, 24'h0},
            // near-triangle, largest step so the phase wraps every transfer
            '{1'b1, REG_WAVE_MIX,   32'h0000_FFFF, 1'b0, 24'h0, 1'b0, 24'h0},
            '{1'b1, REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 24'h0, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'hC0_FFEE, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b1, 24'h80_0000, 1'b0, 24'h0},
            // write to an unmapped index must be ignored
            '{1'b1, REG_UNMAPPED,   32'hFFFF_FFFF, 1'b0, 24'h0, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h3F_0F0F, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b1, 24'hFF_FFFF, 1'b0, 24'h0},
            '{1'b0, REG_UNMAPPED, 32'd0, 1'b0, 24'h00_0000, 1'b0, 24'h0}
        };

        // predictor reset state
        for (int k = 0; k < ROM_LEN; k++)
            sine_quarter[k] = sine_rom_value(k);
        for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < TAP_LEN; k++)
                tap_store[c][k] = '0;
            tap_wr_pos[c] = '0;
            lfo_acc[c]    = '0;
        end
        cfg_step  = STEP_DEFAULT;
        cfg_depth = '0;
        cfg_mix   = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (row = 0; row < DIR_ROWS; row++) begin
            if (directed[row].is_cfg)
                write_reg(directed[row].reg_idx, directed[row].reg_val);
            else
                send_sample(directed[row].chan, directed[row].smp,
                            directed[row].typed, directed[row].want);
        end

        // random phases, each under its own register setting
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == 2)
                step_val = 32'd0;
            else if (phase == 5)
                step_val = 32'hFFFF_FFFF;
            else if ($urandom_range(1) == 0)
                step_val = $urandom;
            else
                step_val = $urandom_range(32'h0010_0000);
            depth_val = (phase == 0) ? 16'hFFFF :
                        (phase == 3) ? 16'h0000 : 16'($urandom_range(16'hFFFF));
            mix_val   = (phase == 1) ? 16'hFFFF :
                        (phase == 4) ? 16'h0000 : 16'($urandom_range(16'hFFFF));
            write_reg(REG_PHASE_STEP, step_val);
            write_reg(REG_DEPTH_KNOB, 32'(depth_val));
            write_reg(REG_WAVE_MIX, 32'(mix_val));

            // bursts with random gaps, some back to back
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 24);
                for (int n = 0; n < burst && sent < ITEMS_PER_PHASE; n++) begin
                    send_sample(1'($urandom_range(1)), random_sample(), 1'b0, '0);
                    sent++;
                end
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
